/* design/ordered_list_store_macros.svh */
// Assertion macros for the ordered list store RTL.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef ORDERED_LIST_STORE_MACROS_SVH
`define ORDERED_LIST_STORE_MACROS_SVH

// A condition that must hold at every clock edge outside reset.
`define OLST_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// A consequence that must hold in the same cycle as its trigger.
`define OLST_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// A consequence that must hold in the cycle after its trigger.
`define OLST_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/olst_pkg.sv */
// Package for the ordered list store: command and result word types,
// operation codes and controller states. Depends on nothing.
package olst_pkg;

  localparam int VALUE_W  = 32;
  localparam int OPCODE_W = 2;
  localparam int LENGTH_W = 5;

  typedef enum logic [OPCODE_W-1:0] {
    OP_PUSH_FRONT = 2'd0,
    OP_PUSH_BACK  = 2'd1,
    OP_DELETE     = 2'd2
  } olst_op_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_WALK = 1'b1
  } olst_state_t;

  typedef struct packed {
    logic [OPCODE_W-1:0]       opcode;
    logic signed [VALUE_W-1:0] value;
  } olst_cmd_t;

  typedef struct packed {
    logic                accepted;
    logic                found;
    logic [LENGTH_W-1:0] length;
  } olst_rsp_t;

endpackage

/* design/olst_mem.sv */
// Entry store of the ordered list: one write port and one read port with
// registered read data. Depends on olst_pkg for the word width.
module olst_mem
  import olst_pkg::*;
#(
  parameter int CAPACITY = 16,
  parameter int AW       = $clog2(CAPACITY)
) (
  input  logic               clk,
  input  logic               we,
  input  logic [AW-1:0]      waddr,
  input  logic [VALUE_W-1:0] wdata,
  input  logic               re,
  input  logic [AW-1:0]      raddr,
  output logic [VALUE_W-1:0] rdata
);

  logic [VALUE_W-1:0] mem [CAPACITY];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* design/olst_ctrl.sv */
// Controller of the ordered list store: command decode, list pointers,
// delete walk and result register. Depends on olst_pkg and the macro header.
`include "ordered_list_store_macros.svh"

module olst_ctrl
  import olst_pkg::*;
#(
  parameter int CAPACITY = 16,
  parameter int AW       = $clog2(CAPACITY),
  parameter int CW       = $clog2(CAPACITY + 1)
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  olst_cmd_t          cmd,
  output logic               done,
  output olst_rsp_t          rsp,
  output logic               mem_we,
  output logic [AW-1:0]      mem_waddr,
  output logic [VALUE_W-1:0] mem_wdata,
  output logic               mem_re,
  output logic [AW-1:0]      mem_raddr,
  input  logic [VALUE_W-1:0] mem_rdata
);

  localparam logic [AW-1:0]   LAST_IDX = AW'(CAPACITY - 1);
  localparam logic [CW-1:0]   CAP_CNT  = CW'(CAPACITY);
  localparam logic [CW:0]     CAP_SUM  = (CW + 1)'(CAPACITY);

  olst_state_t        state, state_next;
  logic [CW-1:0]      count, count_next;
  logic [AW-1:0]      front, front_next;
  logic [AW-1:0]      rd_ptr, rd_ptr_next;
  logic [AW-1:0]      wr_ptr, wr_ptr_next;
  logic [CW-1:0]      rd_cnt, rd_cnt_next;
  logic [CW-1:0]      kept, kept_next;
  logic               found, found_next;
  logic [VALUE_W-1:0] val, val_next;
  logic               rd_vld, rd_vld_next;
  logic               done_next;
  olst_rsp_t          rsp_next;

  logic               accept;
  logic               full;
  logic [AW-1:0]      prev_front;
  logic [CW:0]        back_sum;
  logic [AW-1:0]      back_idx;

  function automatic logic [AW-1:0] inc_idx(input logic [AW-1:0] idx);
    return (idx == LAST_IDX) ? '0 : idx + 1'b1;
  endfunction

  assign busy       = (state != ST_IDLE);
  assign accept     = start && !busy;
  assign full       = (count == CAP_CNT);
  assign prev_front = (front == '0) ? LAST_IDX : front - 1'b1;
  assign back_sum   = (CW + 1)'(front) + (CW + 1)'(count);
  assign back_idx   = (back_sum >= CAP_SUM) ? AW'(back_sum - CAP_SUM) : AW'(back_sum);

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      count  <= '0;
      front  <= '0;
      rd_vld <= 1'b0;
      done   <= 1'b0;
    end else begin
      state  <= state_next;
      count  <= count_next;
      front  <= front_next;
      rd_vld <= rd_vld_next;
      done   <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    rd_ptr <= rd_ptr_next;
    wr_ptr <= wr_ptr_next;
    rd_cnt <= rd_cnt_next;
    kept   <= kept_next;
    found  <= found_next;
    val    <= val_next;
    rsp    <= rsp_next;
  end

  always_comb begin
    state_next  = state;
    count_next  = count;
    front_next  = front;
    rd_ptr_next = rd_ptr;
    wr_ptr_next = wr_ptr;
    rd_cnt_next = rd_cnt;
    kept_next   = kept;
    found_next  = found;
    val_next    = val;
    rd_vld_next = 1'b0;
    done_next   = 1'b0;
    rsp_next    = rsp;
    mem_we      = 1'b0;
    mem_waddr   = wr_ptr;
    mem_wdata   = cmd.value;
    mem_re      = 1'b0;
    mem_raddr   = rd_ptr;

    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          unique case (cmd.opcode) inside
            OP_PUSH_FRONT, OP_PUSH_BACK: begin
              done_next        = 1'b1;
              rsp_next.found   = 1'b0;
              rsp_next.accepted = !full;
              rsp_next.length  = LENGTH_W'(count);
              if (!full) begin
                mem_we          = 1'b1;
                count_next      = count + 1'b1;
                rsp_next.length = LENGTH_W'(count + 1'b1);
                if (cmd.opcode == OP_PUSH_FRONT) begin
                  front_next = prev_front;
                  mem_waddr  = prev_front;
                end else begin
                  mem_waddr = back_idx;
                end
              end
            end
            OP_DELETE: begin
              state_next  = ST_WALK;
              rd_ptr_next = front;
              wr_ptr_next = front;
              rd_cnt_next = '0;
              kept_next   = '0;
              found_next  = 1'b0;
              val_next    = cmd.value;
            end
            default: begin
              done_next         = 1'b1;
              rsp_next.accepted = 1'b0;
              rsp_next.found    = 1'b0;
              rsp_next.length   = LENGTH_W'(count);
            end
          endcase
        end
      end
      ST_WALK: begin
        mem_re      = (rd_cnt != count);
        rd_vld_next = mem_re;
        if (mem_re) begin
          rd_ptr_next = inc_idx(rd_ptr);
          rd_cnt_next = rd_cnt + 1'b1;
        end
        if (rd_vld) begin
          if (mem_rdata == val) begin
            found_next = 1'b1;
          end else begin
            mem_we      = 1'b1;
            mem_waddr   = wr_ptr;
            mem_wdata   = mem_rdata;
            wr_ptr_next = inc_idx(wr_ptr);
            kept_next   = kept + 1'b1;
          end
        end
        if (!mem_re && !rd_vld) begin
          state_next        = ST_IDLE;
          count_next        = kept;
          done_next         = 1'b1;
          rsp_next.accepted = 1'b1;
          rsp_next.found    = found;
          rsp_next.length   = LENGTH_W'(kept);
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  `OLST_ASSERT_ALWAYS(a_count_bound, (count <= CAP_CNT) && (front <= LAST_IDX), "list bounds broken")
  `OLST_ASSERT_IMPL(a_kept_behind, state == ST_WALK, kept <= rd_cnt, "compaction ran ahead of walk")
  `OLST_ASSERT_IMPL(a_no_overlap, mem_we && mem_re, mem_waddr != mem_raddr, "write hit read entry")
  `OLST_ASSERT_NEXT(a_delete_walks, accept && (cmd.opcode == OP_DELETE), busy && !done, "delete did not walk")

endmodule

/* design/ordered_list_store.sv */
// Ordered list store: a bounded list of signed 32-bit words kept in a
// circular entry memory. An insert at either end answers in the cycle after
// start and leaves busy low. A delete walks the stored entries through the
// single read port of the memory and compacts the survivors behind the walk;
// busy stays high through the walk and the result strobes at the end. Every
// accepted command gives exactly one result word, shown for one cycle under
// done; the receiver cannot stall it. Reset needs no clearing pass. The
// length field reports the count modulo 32.
module ordered_list_store
  import olst_pkg::*;
#(
  parameter int CAPACITY = 16
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  output logic      busy,
  input  olst_cmd_t cmd,
  output logic      done,
  output olst_rsp_t rsp
);

  localparam int AW = $clog2(CAPACITY);

  logic               mem_we;
  logic [AW-1:0]      mem_waddr;
  logic [VALUE_W-1:0] mem_wdata;
  logic               mem_re;
  logic [AW-1:0]      mem_raddr;
  logic [VALUE_W-1:0] mem_rdata;

  olst_ctrl #(
    .CAPACITY (CAPACITY),
    .AW       (AW)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .cmd       (cmd),
    .done      (done),
    .rsp       (rsp),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  olst_mem #(
    .CAPACITY (CAPACITY),
    .AW       (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

endmodule

/* bench/list_result_checker.sv */
// Result checker for the ordered list store: keeps a shadow copy of the list,
// predicts one result word per accepted command word and compares it with done/rsp.
// Depends on olst_pkg for the command and result word types and operation codes.
module list_result_checker
  import olst_pkg::*;
#(
  parameter int CAPACITY = 16
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  input  logic      busy,
  input  olst_cmd_t cmd,
  input  logic      done,
  input  olst_rsp_t rsp,
  output int        fail_count,
  output int        words_waiting,
  output int        words_checked,
  output int        refused_inserts,
  output int        delete_hits
);
  timeunit 1ns;
  timeprecision 1ps;

  logic signed [VALUE_W-1:0] shadow_entries [CAPACITY];
  int                        shadow_front;
  int                        shadow_count;
  olst_rsp_t                 predicted_rsp_q [$];

  task automatic predict_list_op(input olst_cmd_t w, output olst_rsp_t r);
    int kept;
    int i;
    logic signed [VALUE_W-1:0] e;
    r = '0;
    case (w.opcode)
      OP_PUSH_FRONT, OP_PUSH_BACK: begin
        if (shadow_count < CAPACITY) begin
          if (w.opcode == OP_PUSH_FRONT) begin
            shadow_front = (shadow_front + CAPACITY - 1) % CAPACITY;
            shadow_entries[shadow_front] = w.value;
          end else begin
            shadow_entries[(shadow_front + shadow_count) % CAPACITY] = w.value;
          end
          shadow_count++;
          r.accepted = 1'b1;
        end else begin
          refused_inserts++;
        end
      end
      OP_DELETE: begin
        kept = 0;
        for (i = 0; i < shadow_count; i++) begin
          e = shadow_entries[(shadow_front + i) % CAPACITY];
          if (e == w.value) begin
            r.found = 1'b1;
          end else begin
            shadow_entries[(shadow_front + kept) % CAPACITY] = e;
            kept++;
          end
        end
        shadow_count = kept;
        r.accepted = 1'b1;
        if (r.found) delete_hits++;
      end
      default: begin
      end
    endcase
    r.length = shadow_count[LENGTH_W-1:0];
  endtask

  always @(posedge clk) begin
    olst_rsp_t predicted;
    olst_rsp_t want;
    if (rst) begin
      shadow_front = 0;
      shadow_count = 0;
      predicted_rsp_q.delete();
      words_waiting = 0;
    end else begin
      if (start && !busy) begin
        predict_list_op(cmd, predicted);
        predicted_rsp_q.push_back(predicted);
        words_waiting++;
      end
      if (done) begin
        if (predicted_rsp_q.size() == 0) begin
          fail_count++;
          $display("%0t ns: result word with none expected,", $time,
                   " actual accepted=%0b found=%0b length=%0d",
                   rsp.accepted, rsp.found, rsp.length);
        end else begin
          want = predicted_rsp_q.pop_front();
          words_waiting--;
          words_checked++;
          if (rsp !== want) begin
            fail_count++;
            $display("%0t ns: result word mismatch,", $time,
                     " expected accepted=%0b found=%0b length=%0d,",
                     want.accepted, want.found, want.length,
                     " actual accepted=%0b found=%0b length=%0d",
                     rsp.accepted, rsp.found, rsp.length);
          end
        end
      end
    end
  end

endmodule

/* bench/testbench.sv */
// Top of the ordered list store bench: clock, reset and command words, directed
// first and then random under three idle profiles. Depends on olst_pkg,
// ordered_list_store and list_result_checker.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import olst_pkg::*;

  localparam int CAPACITY     = 16;
  localparam int RANDOM_WORDS = 1500;
  localparam int CYCLE_LIMIT  = 400000;
  localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;
  localparam logic signed [VALUE_W-1:0] VALUE_MIN = 32'sh8000_0000;
  localparam logic signed [VALUE_W-1:0] VALUE_MAX = 32'sh7fff_ffff;

  logic      clk;
  logic      rst;
  logic      start;
  logic      busy;
  olst_cmd_t cmd;
  logic      done;
  olst_rsp_t rsp;

  int fail_count;
  int words_waiting;
  int words_checked;
  int refused_inserts;
  int delete_hits;
  int cycle_count = 0;
  int idle_pct;

  ordered_list_store #(.CAPACITY(CAPACITY)) DUT (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .cmd   (cmd),
    .done  (done),
    .rsp   (rsp)
  );

  list_result_checker #(.CAPACITY(CAPACITY)) result_check (
    .clk             (clk),
    .rst             (rst),
    .start           (start),
    .busy            (busy),
    .cmd             (cmd),
    .done            (done),
    .rsp             (rsp),
    .fail_count      (fail_count),
    .words_waiting   (words_waiting),
    .words_checked   (words_checked),
    .refused_inserts (refused_inserts),
    .delete_hits     (delete_hits)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Run stopped after %0d cycles with %0d result words outstanding.",
               cycle_count, words_waiting);
      $display("** ordered_list_store: FAILED **");
      $finish;
    end
  end

  task automatic send_word(input logic [OPCODE_W-1:0] op,
                           input logic signed [VALUE_W-1:0] v);
    olst_cmd_t w;
    w.opcode = op;
    w.value  = v;
    start <= 1'b1;
    cmd   <= w;
    @(posedge clk);
    while (busy) @(posedge clk);
    while (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
      w.opcode = OPCODE_W'($urandom_range(0, 3));
      w.value  = $urandom;
      start <= 1'b0;
      cmd   <= w;
      @(posedge clk);
    end
  endtask

  initial begin
    logic signed [VALUE_W-1:0] value_pool [8];
    logic signed [VALUE_W-1:0] v;
    logic [OPCODE_W-1:0]       op;
    int                        pool_size;
    int                        roll;
    bit                        drain_bias;
    int                        n;
    int                        k;

    rst      = 1'b1;
    start    = 1'b0;
    cmd      = '0;
    idle_pct = 0;
    pool_size = 1;
    drain_bias = 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    send_word(OP_DELETE, '0);
    send_word(OP_PUSH_FRONT, VALUE_MIN);
    send_word(OP_PUSH_BACK, VALUE_MAX);
    send_word(OP_PUSH_BACK, '0);
    for (k = 0; k < CAPACITY - 3; k++)
      send_word((k % 2) ? OP_PUSH_FRONT : OP_PUSH_BACK, 32'sd7);
    send_word(OP_PUSH_BACK, 32'sd99);
    send_word(OP_DELETE, 32'sd7);
    send_word(OP_DELETE, VALUE_MAX);
    send_word(OP_DELETE, 32'sd1234);
    send_word(OP_UNUSED, 32'sd5);
    send_word(OP_DELETE, VALUE_MIN);
    send_word(OP_DELETE, '0);
    send_word(OP_PUSH_FRONT, -32'sd1);

    for (n = 0; n < RANDOM_WORDS; n++) begin
      if (n < RANDOM_WORDS / 3) idle_pct = 33;
      else if (n < 2 * RANDOM_WORDS / 3) idle_pct = 53;
      else idle_pct = 0;

      if (n % 48 == 0) begin
        pool_size  = $urandom_range(1, 8);
        drain_bias = 1'($urandom_range(0, 1));
        for (k = 0; k < 8; k++) begin
          case ($urandom_range(0, 7))
            0: value_pool[k] = VALUE_MIN;
            1: value_pool[k] = VALUE_MAX;
            2: value_pool[k] = '0;
            3: value_pool[k] = '1;
            default: value_pool[k] = $urandom;
          endcase
        end
      end

      roll = $urandom_range(0, 99);
      if (drain_bias) begin
        if (roll < 20) op = OP_PUSH_FRONT;
        else if (roll < 40) op = OP_PUSH_BACK;
        else if (roll < 95) op = OP_DELETE;
        else op = OP_UNUSED;
      end else begin
        if (roll < 38) op = OP_PUSH_FRONT;
        else if (roll < 76) op = OP_PUSH_BACK;
        else if (roll < 97) op = OP_DELETE;
        else op = OP_UNUSED;
      end

      if ($urandom_range(0, 9) == 0) v = $urandom;
      else v = value_pool[$urandom_range(0, pool_size - 1)];

      send_word(op, v);
    end

    start <= 1'b0;
    @(posedge clk);
    while (words_waiting != 0) @(posedge clk);
    repeat (CAPACITY + 4) @(posedge clk);

    $display("Checked %0d result words, directed and random, under three idle profiles.",
             words_checked);
    $display("Deletes that removed entries: %0d; inserts refused by a full list: %0d.",
             delete_hits, refused_inserts);
    if (fail_count == 0) begin
      $display("** ordered_list_store: PASSED **");
    end else begin
      $display("** ordered_list_store: FAILED **");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+design
design/olst_pkg.sv
design/olst_mem.sv
design/olst_ctrl.sv
design/ordered_list_store.sv
bench/list_result_checker.sv
bench/testbench.sv
